// ===== hdl/akwq_pkg.sv =====
// ----------------------------------------------------------------------------
// akwq_pkg
// Shared types and codes of the address-keyed wait queue table.
// ----------------------------------------------------------------------------
package akwq_pkg;

    localparam logic [1:0] REQ_WAIT    = 2'd0;
    localparam logic [1:0] REQ_WAKE    = 2'd1;
    localparam logic [1:0] REQ_REQUEUE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_WOKEN   = 2'd1;
    localparam logic [1:0] EV_DROPPED = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] thread_event;
        logic [4:0] event_thread;
        logic [5:0] woken_count;
    } akwq_res_t;

endpackage

// ===== hdl/akwq_ram.sv =====
// ----------------------------------------------------------------------------
// akwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module akwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/address_keyed_wait_queue_table_unit.sv =====
// ----------------------------------------------------------------------------
// address_keyed_wait_queue_table_unit
// Futex-style table of address-keyed FIFO wait queues: wait, wake, requeue.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_ axis  | in        | one request (tuser: req_type)
//  m_axis   | out       | result items, tlast on the final one of a request
//
//  A request is taken only while the sequencer is idle. A key lookup reads the
//  key RAM one entry a cycle, up to a hit or the last entry. Each woken thread
//  is popped with a next-pointer RAM read (S_POP, S_NEXT); each moved thread
//  is popped the same way, then looked up by target key and enqueued (S_ACT).
//  Reset clears the valid, count and waiting flags; no clearing pass.
//  A stalled m_ side holds the sequencer at the next result it must send.
// ----------------------------------------------------------------------------
module address_keyed_wait_queue_table_unit
    import akwq_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int THREADS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_addr[31:0] target_addr[63:32] thread_id[68:64] compare_value[100:69]
    // memory_value[132:101] wake_all[133] wake_limit[139:134]
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0] event_thread[6:2] woken_count[12:7]
    output logic [15:0]  m_tdata,
    output logic [1:0]   m_tuser,   // thread_event[1:0]
    output logic         m_tlast
);
    localparam int EW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
    localparam int TW = THREADS > 1 ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ACT   = 6'b000100,
        S_POP   = 6'b001000,
        S_NEXT  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [31:0] key_reg, tgt_reg;
    logic [4:0]  tid_reg;
    logic        all_reg;
    logic [5:0]  lim_reg;
    logic [5:0]  woken_reg;
    logic [6:0]  n_reg;
    logic [CW-1:0] rest_reg;
    logic        moving_reg;
    logic [EW-1:0] e_reg;
    logic [TW-1:0] cur_t_reg;
    logic [EW:0] scan_cnt_reg;
    logic        rd_v_reg;
    logic [EW-1:0] rd_idx_reg;
    logic        found_reg;
    logic [EW-1:0] fidx_reg;

    logic          valid_reg   [ENTRIES];
    logic [CW-1:0] cnt_reg     [ENTRIES];
    logic [TW-1:0] head_reg    [ENTRIES];
    logic [TW-1:0] tail_reg    [ENTRIES];
    logic          waiting_reg [THREADS];

    akwq_res_t pend_reg, out_reg;
    logic      pend_v_reg, out_v_reg, out_last_reg;

    logic        out_free;
    logic        key_we, nxt_we;
    logic [EW-1:0] key_waddr;
    logic [31:0] key_wdata, key_rdata, scan_key;
    logic [TW-1:0] nxt_waddr, nxt_wdata, nxt_rdata;
    logic        free_any;
    logic [EW-1:0] free_idx;
    logic [EW-1:0] dst;
    logic [TW-1:0] enq_t;
    logic        s_hit;

    assign out_free = !out_v_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'd0, out_reg.woken_count, out_reg.event_thread, out_reg.status};
    assign m_tuser  = out_reg.thread_event;
    assign m_tlast  = out_last_reg;
    assign scan_key = moving_reg ? tgt_reg : key_reg;
    assign s_hit    = rd_v_reg && valid_reg[rd_idx_reg] && (key_rdata == scan_key);

    // highest free entry
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = EW'(i);
            end
        end
    end

    assign dst   = found_reg ? fidx_reg : free_idx;
    assign enq_t = moving_reg ? cur_t_reg : TW'(tid_reg);

    always_comb begin
        key_we    = 1'b0;
        key_waddr = free_idx;
        key_wdata = scan_key;
        nxt_we    = 1'b0;
        nxt_waddr = tail_reg[dst];
        nxt_wdata = enq_t;
        if (state_reg == S_ACT && out_free && (op_reg == REQ_WAIT || moving_reg)
            && (found_reg || free_any)) begin
            key_we = !found_reg;
            nxt_we = found_reg && (cnt_reg[dst] != '0);
        end
    end

    akwq_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (scan_cnt_reg[EW-1:0]),
        .rdata (key_rdata)
    );

    akwq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_next_ram (
        .aclk  (aclk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (head_reg[e_reg]),
        .rdata (nxt_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_WAIT) begin
                        if (s_tdata[100:69] != s_tdata[132:101]
                            || 7'(s_tdata[68:64]) >= 7'(THREADS)
                            || waiting_reg[TW'(s_tdata[68:64])]) begin
                            state_next = S_FLUSH;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (s_tuser == REQ_WAKE) begin
                        state_next = S_SCAN;
                    end else if (s_tuser == REQ_REQUEUE) begin
                        state_next = (s_tdata[100:69] != s_tdata[132:101]) ? S_FLUSH : S_SCAN;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_SCAN: begin
                if (s_hit || (rd_v_reg && rd_idx_reg == EW'(ENTRIES - 1))) begin
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                if (out_free) begin
                    if (op_reg == REQ_WAIT) begin
                        state_next = S_FLUSH;
                    end else if (!moving_reg && !found_reg) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP: begin
                state_next = (n_reg != '0 || rest_reg != '0) ? S_NEXT : S_FLUSH;
            end
            S_NEXT: begin
                if (out_free) begin
                    state_next = (n_reg != '0) ? S_POP : S_SCAN;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            rd_v_reg   <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                cnt_reg[i]   <= '0;
            end
            for (int j = 0; j < THREADS; j++) begin
                waiting_reg[j] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (out_v_reg && m_tready) begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= s_tuser;
                        key_reg      <= s_tdata[31:0];
                        tgt_reg      <= s_tdata[63:32];
                        tid_reg      <= s_tdata[68:64];
                        all_reg      <= s_tdata[133];
                        lim_reg      <= s_tdata[139:134];
                        woken_reg    <= '0;
                        moving_reg   <= 1'b0;
                        scan_cnt_reg <= '0;
                        rd_v_reg     <= 1'b0;
                        pend_reg     <= '0;
                        pend_v_reg   <= 1'b0;
                        if (s_tuser == REQ_WAIT) begin
                            if (s_tdata[100:69] != s_tdata[132:101]) begin
                                pend_reg.status <= ST_MISMATCH;
                                pend_v_reg      <= 1'b1;
                            end else if (7'(s_tdata[68:64]) >= 7'(THREADS)) begin
                                pend_reg.status <= ST_FULL;
                                pend_v_reg      <= 1'b1;
                            end
                        end else if (s_tuser == REQ_REQUEUE
                                     && s_tdata[100:69] != s_tdata[132:101]) begin
                            pend_reg.status <= ST_MISMATCH;
                            pend_v_reg      <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_cnt_reg < (EW+1)'(ENTRIES)) begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        rd_v_reg     <= 1'b1;
                        rd_idx_reg   <= scan_cnt_reg[EW-1:0];
                    end else begin
                        rd_v_reg <= 1'b0;
                    end
                    found_reg <= s_hit;
                    fidx_reg  <= rd_idx_reg;
                end
                S_ACT: begin
                    if (out_free) begin
                        if (op_reg == REQ_WAIT || moving_reg) begin
                            if (found_reg || free_any) begin
                                // enqueue into dst
                                if (!found_reg) begin
                                    valid_reg[dst] <= 1'b1;
                                end
                                if (!found_reg || cnt_reg[dst] == '0) begin
                                    head_reg[dst] <= enq_t;
                                    cnt_reg[dst]  <= CW'(1);
                                end else begin
                                    cnt_reg[dst]  <= cnt_reg[dst] + 1'b1;
                                end
                                tail_reg[dst]      <= enq_t;
                                waiting_reg[enq_t] <= 1'b1;
                            end else if (op_reg == REQ_WAIT) begin
                                pend_reg.status <= ST_FULL;
                                pend_v_reg      <= 1'b1;
                            end else begin
                                // drop: pass previous pending result on
                                if (pend_v_reg) begin
                                    out_reg      <= pend_reg;
                                    out_last_reg <= 1'b0;
                                    out_v_reg    <= 1'b1;
                                end
                                pend_reg.status       <= ST_OK;
                                pend_reg.thread_event <= EV_DROPPED;
                                pend_reg.event_thread <= 5'(cur_t_reg);
                                pend_reg.woken_count  <= woken_reg;
                                pend_v_reg            <= 1'b1;
                            end
                        end else if (found_reg) begin
                            e_reg <= fidx_reg;
                            if (all_reg || 7'(lim_reg) >= 7'(cnt_reg[fidx_reg])) begin
                                n_reg    <= 7'(cnt_reg[fidx_reg]);
                                rest_reg <= '0;
                            end else begin
                                n_reg    <= 7'(lim_reg);
                                rest_reg <= (op_reg == REQ_REQUEUE)
                                    ? CW'(cnt_reg[fidx_reg] - CW'(lim_reg)) : '0;
                            end
                        end
                    end
                end
                S_POP: begin
                    cur_t_reg <= head_reg[e_reg];
                end
                S_NEXT: begin
                    if (out_free) begin
                        // dequeue cur_t from e_reg
                        head_reg[e_reg]        <= nxt_rdata;
                        waiting_reg[cur_t_reg] <= 1'b0;
                        cnt_reg[e_reg]         <= cnt_reg[e_reg] - 1'b1;
                        if (cnt_reg[e_reg] == CW'(1)) begin
                            valid_reg[e_reg] <= 1'b0;
                        end
                        if (n_reg != '0) begin
                            n_reg     <= n_reg - 1'b1;
                            woken_reg <= woken_reg + 1'b1;
                            if (pend_v_reg) begin
                                out_reg      <= pend_reg;
                                out_last_reg <= 1'b0;
                                out_v_reg    <= 1'b1;
                            end
                            pend_reg.status       <= ST_OK;
                            pend_reg.thread_event <= EV_WOKEN;
                            pend_reg.event_thread <= 5'(cur_t_reg);
                            pend_reg.woken_count  <= woken_reg + 1'b1;
                            pend_v_reg            <= 1'b1;
                        end else begin
                            rest_reg     <= rest_reg - 1'b1;
                            moving_reg   <= 1'b1;
                            scan_cnt_reg <= '0;
                            rd_v_reg     <= 1'b0;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        out_reg      <= pend_v_reg ? pend_reg : '0;
                        out_last_reg <= 1'b1;
                        out_v_reg    <= 1'b1;
                        pend_v_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/akwq_checker.sv =====
// ----------------------------------------------------------------------------
// akwq_checker
// Port-level checks of the wait queue table, bound to the top level.
// ----------------------------------------------------------------------------
module akwq_checker
    import akwq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no new request while one is still sending results
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken mid-transfer");

    // a result without an event closes its request
    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_NONE |-> m_tlast)
        else $error("event-free result not last");

    // a failing status never comes with an event
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tuser == EV_NONE && m_tlast)
        else $error("error status with thread event");
endmodule

bind address_keyed_wait_queue_table_unit akwq_checker u_akwq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
